>>> design/presence_sensor_averager_defines.svh
// assertion macros for the presence sensor averager
`ifndef PRESENCE_SENSOR_AVERAGER_DEFINES_SVH
`define PRESENCE_SENSOR_AVERAGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/psa_pkg.sv
// shared types and constants of the presence sensor averager
package psa_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_LONG_PRESS = 1'b0,
    CFG_THRESHOLD  = 1'b1
  } cfg_index_t;

  localparam int CFG_DATA_W    = 16;
  localparam int LONG_PRESS_W  = 16;
  localparam int THRESHOLD_W   = 9;
  localparam int TIME_W        = 32;

  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = 16'd2500;
  localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET  = 9'd100;

  // scale factors applied before the division by full scale
  localparam int SHORT_SPAN    = 63;
  localparam int LONG_SPAN     = 127;
  localparam int SHORT_SCALE_W = 6;
  localparam int LONG_SCALE_W  = 7;

  // output sum widths and their saturation limits
  localparam int SUM_SHORT_W = 8;
  localparam int SUM_LONG_W  = 9;
  localparam int SUM_SHORT_MAX = 255;
  localparam int SUM_LONG_MAX  = 511;

endpackage

>>> design/presence_sensor_averager.sv
// presence sensor averager top level
// One sensor tick per transaction. Every cycle a new tick can be taken, and
// each tick gives exactly one result transaction. The accept edge scales the
// three readings (x*63/full or x*127/full, done as a constant multiply and a
// single compare-and-increment correction), stores them into per-sensor rings
// of WINDOW flip-flop entries and evaluates the button edge; the result
// register then takes the saturated ring sums, their maximum and the presence
// flags. Both stages stall together when the result is not taken, so while a
// result waits in the output register with out_ready low, in_ready is low too
// and the next tick is held off; with out_ready high the block takes a tick in
// every cycle. Configuration writes are always taken (index 0: long-press
// limit in ms, index 1: presence threshold) and are meant for idle periods
// only. There is no clearing pass after reset.
module presence_sensor_averager #(
  parameter int WINDOW      = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  psa_pkg::cfg_index_t                 cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                button_level,
  input  logic [SAMPLE_BITS-1:0]              sample_a,
  input  logic [SAMPLE_BITS-1:0]              sample_b,
  input  logic [SAMPLE_BITS-1:0]              sample_long,
  input  logic [psa_pkg::TIME_W-1:0]          now_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                short_press,
  output logic                                long_press,
  output logic [psa_pkg::SUM_SHORT_W-1:0]     sum_a,
  output logic [psa_pkg::SUM_SHORT_W-1:0]     sum_b,
  output logic [psa_pkg::SUM_LONG_W-1:0]      sum_long,
  output logic [psa_pkg::SUM_LONG_W-1:0]      max_sum,
  output logic                                present,
  output logic                                was_present
);
  import psa_pkg::*;
  `include "presence_sensor_averager_defines.svh"

  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int PROD_W   = SAMPLE_BITS + LONG_SCALE_W;
  localparam int RAW_NEED = $clog2(WINDOW * LONG_SPAN + 1);
  // raw sums are never narrower than the saturated long sum
  localparam int RAW_W    = (RAW_NEED > SUM_LONG_W) ? RAW_NEED : SUM_LONG_W;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

  // x*span/full with full = 2^n-1: the shifted estimate is low by at most one
  function automatic logic [LONG_SCALE_W-1:0] scale_div(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [LONG_SCALE_W-1:0] span
  );
    logic [PROD_W-1:0]        prod;
    logic [LONG_SCALE_W-1:0]  quot;
    logic [SAMPLE_BITS:0]     rem;
    prod = PROD_W'(x) * PROD_W'(span);
    quot = prod[PROD_W-1:SAMPLE_BITS];
    rem  = {1'b0, prod[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(quot);
    if (rem >= {1'b0, FULL_SCALE}) begin
      quot = quot + 1'b1;
    end
    return quot;
  endfunction

  // configuration registers
  logic [LONG_PRESS_W-1:0] long_press_ms;
  logic [THRESHOLD_W-1:0]  presence_threshold;

  // first stage: rings, button tracking, press flags
  logic [SHORT_SCALE_W-1:0] ring_a    [WINDOW];
  logic [SHORT_SCALE_W-1:0] ring_b    [WINDOW];
  logic [LONG_SCALE_W-1:0]  ring_long [WINDOW];
  logic [SLOT_W-1:0]        write_slot;
  logic [SLOT_W-1:0]        write_slot_next;
  logic                     last_button;
  logic [TIME_W-1:0]        press_start;
  logic                     s1_valid;
  logic                     s1_short;
  logic                     s1_long;

  // second stage state
  logic                     last_presence;

  // combinational values
  logic                     advance;
  logic                     in_fire;
  logic [TIME_W-1:0]        held_ms;
  logic                     is_short;
  logic [SHORT_SCALE_W-1:0] scaled_a;
  logic [SHORT_SCALE_W-1:0] scaled_b;
  logic [LONG_SCALE_W-1:0]  scaled_long;
  logic [RAW_W-1:0]         raw_a;
  logic [RAW_W-1:0]         raw_b;
  logic [RAW_W-1:0]         raw_long;
  logic [SUM_SHORT_W-1:0]   sat_a;
  logic [SUM_SHORT_W-1:0]   sat_b;
  logic [SUM_LONG_W-1:0]    sat_long;
  logic [SUM_LONG_W-1:0]    max_ab;
  logic [SUM_LONG_W-1:0]    max_all;
  logic                     pres_next;

  // both stages move together, so the second stage always sees the rings
  // exactly as its own tick left them
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms      <= LONG_PRESS_RESET;
      presence_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_ms      <= cfg_data[LONG_PRESS_W-1:0];
        CFG_THRESHOLD:  presence_threshold <= cfg_data[THRESHOLD_W-1:0];
      endcase
    end
  end

  // press length wraps with the millisecond counter
  assign held_ms  = now_ms - press_start;
  assign is_short = held_ms < TIME_W'(long_press_ms);

  // the slot advances before the write, so the first tick lands in slot 1
  assign write_slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                               : write_slot + 1'b1;

  // readings are scaled on entry so the rings hold only small values
  assign scaled_a    = SHORT_SCALE_W'(scale_div(sample_a, LONG_SCALE_W'(SHORT_SPAN)));
  assign scaled_b    = SHORT_SCALE_W'(scale_div(sample_b, LONG_SCALE_W'(SHORT_SPAN)));
  assign scaled_long = scale_div(sample_long, LONG_SCALE_W'(LONG_SPAN));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_a[i]    <= '0;
        ring_b[i]    <= '0;
        ring_long[i] <= '0;
      end
      write_slot  <= '0;
      last_button <= 1'b0;
      press_start <= '0;
      s1_valid    <= 1'b0;
      s1_short    <= 1'b0;
      s1_long     <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_fire;
      if (in_fire) begin
        // rising edge starts a press, falling edge classifies it
        if (!last_button && button_level) begin
          press_start <= now_ms;
        end
        s1_short    <= last_button && !button_level && is_short;
        s1_long     <= last_button && !button_level && !is_short;
        last_button <= button_level;
        write_slot  <= write_slot_next;
        ring_a[write_slot_next]    <= scaled_a;
        ring_b[write_slot_next]    <= scaled_b;
        ring_long[write_slot_next] <= scaled_long;
      end
    end
  end

  // ring sums over all entries
  always_comb begin
    raw_a    = '0;
    raw_b    = '0;
    raw_long = '0;
    for (int i = 0; i < WINDOW; i++) begin
      raw_a    = raw_a + RAW_W'(ring_a[i]);
      raw_b    = raw_b + RAW_W'(ring_b[i]);
      raw_long = raw_long + RAW_W'(ring_long[i]);
    end
  end

  // saturate to the field widths, then pick the largest
  assign sat_a    = (raw_a > RAW_W'(SUM_SHORT_MAX)) ? SUM_SHORT_W'(SUM_SHORT_MAX)
                                                    : raw_a[SUM_SHORT_W-1:0];
  assign sat_b    = (raw_b > RAW_W'(SUM_SHORT_MAX)) ? SUM_SHORT_W'(SUM_SHORT_MAX)
                                                    : raw_b[SUM_SHORT_W-1:0];
  assign sat_long = (raw_long > RAW_W'(SUM_LONG_MAX)) ? SUM_LONG_W'(SUM_LONG_MAX)
                                                      : raw_long[SUM_LONG_W-1:0];
  assign max_ab    = (sat_a > sat_b) ? SUM_LONG_W'(sat_a) : SUM_LONG_W'(sat_b);
  assign max_all   = (sat_long > max_ab) ? sat_long : max_ab;
  assign pres_next = max_all > presence_threshold;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_presence <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        last_presence <= pres_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      short_press <= s1_short;
      long_press  <= s1_long;
      sum_a       <= sat_a;
      sum_b       <= sat_b;
      sum_long    <= sat_long;
      max_sum     <= max_all;
      present     <= pres_next;
      was_present <= last_presence;
    end
  end

  `PSA_ASSERT_NOW(a_press_exclusive, out_valid, !(short_press && long_press), "short and long press both reported")
  `PSA_ASSERT_NOW(a_max_covers, out_valid, (max_sum >= sum_long) && (max_sum >= 9'(sum_a)) && (max_sum >= 9'(sum_b)), "max_sum below a sensor sum")
  `PSA_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, s1_valid, "accepted tick missing from first stage")
  `PSA_ASSERT_NEXT(a_stage_handoff, s1_valid && advance, out_valid, "first stage tick lost before result")

endmodule
